### rtl/ilsf_pkg.sv
// ilsf_pkg: shared constants and types for the IPv4 local service filter.
// No dependencies; imported by ipv4_local_service_filter.
package ilsf_pkg;

    typedef logic [2:0]  cfg_index_t;
    typedef logic [1:0]  if_port_t;
    typedef logic [31:0] ip_addr_t;

    localparam cfg_index_t CFG_LAN_ADDRESS    = 3'd0;
    localparam cfg_index_t CFG_AP_ADDRESS     = 3'd1;
    localparam cfg_index_t CFG_AP_MASK        = 3'd2;
    localparam cfg_index_t CFG_UPLINK_ADDRESS = 3'd3;
    localparam cfg_index_t CFG_UPLINK_MASK    = 3'd4;

    localparam if_port_t PORT_LAN = 2'd0;
    localparam if_port_t PORT_AP  = 2'd1;

    localparam ip_addr_t MDNS_GROUP = 32'hE000_00FB;
    localparam ip_addr_t ADDR_ONES  = 32'hFFFF_FFFF;
    localparam ip_addr_t ADDR_ZERO  = 32'h0000_0000;

    localparam logic [3:0] IP_VERSION4 = 4'd4;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;

    localparam logic [4:0] FRAG_HI_MASK = 5'h1F;

    localparam logic [15:0] MIN_HDR_BYTES  = 16'd20;
    localparam logic [15:0] PORTS_BYTES    = 16'd4;

    // header byte offsets
    localparam logic [15:0] OFS_VIHL      = 16'd0;
    localparam logic [15:0] OFS_LEN_HI    = 16'd2;
    localparam logic [15:0] OFS_LEN_LO    = 16'd3;
    localparam logic [15:0] OFS_FRAG_HI   = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO   = 16'd7;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_DEST_LO   = 16'd16;
    localparam logic [15:0] OFS_DEST_HI   = 16'd19;
    localparam logic [15:0] OFS_DPORT_HI  = 16'd2;
    localparam logic [15:0] OFS_DPORT_LO  = 16'd3;

    localparam logic [15:0] SVC_DNS       = 16'd53;
    localparam logic [15:0] SVC_HTTP      = 16'd80;
    localparam logic [15:0] SVC_HTTPS     = 16'd443;
    localparam logic [15:0] SVC_MDNS      = 16'd5353;
    localparam logic [15:0] SVC_MGMT_A    = 16'd32768;
    localparam logic [15:0] SVC_MGMT_B    = 16'd32769;

endpackage

### rtl/ipv4_local_service_filter.sv
// ipv4_local_service_filter: per-byte IPv4 header capture and last-byte verdict.
// Depends on ilsf_pkg (constants, types).
//
// Packet bytes enter one per request, tagged with the arrival interface, and
// one result (verdict plus the three running counters) comes out for each byte
// marked last. A byte passes through the input register and then the result
// register, and a new byte is taken every cycle; only a result that is not
// taken holds back the byte behind it that also closes a packet. The user must
// write interface addresses and masks through the configuration port while no
// packet is in flight; the block does not enforce this. Its ready is always
// high. Counters wrap at COUNTER_WIDTH bits and report their low 32 bits; the
// byte count saturates at 2^LENGTH_WIDTH-1, after which bytes are not captured.
module ipv4_local_service_filter #(
    parameter int LENGTH_WIDTH  = 16,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ilsf_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           port_in,
    input  logic                 ip6_path,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 verdict,
    output logic [31:0]          lan_rx_total,
    output logic [31:0]          ap_rx_total,
    output logic [31:0]          denied_total
);
    import ilsf_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    // configuration
    ip_addr_t lan_addr_reg, ap_addr_reg, ap_mask_reg, up_addr_reg, up_mask_reg;

    // input register
    logic       item_valid_reg;
    if_port_t   item_port_reg;
    logic       item_ip6_reg;
    logic [7:0] item_byte_reg;
    logic       item_first_reg;
    logic       item_last_reg;

    // capture state
    logic [LENGTH_WIDTH-1:0] byte_index_reg, byte_index_next;
    logic [7:0]              vihl_reg, vihl_next;
    logic [15:0]             len_reg, len_next;
    logic [7:0]              proto_reg, proto_next;
    logic [12:0]             frag_reg, frag_next;
    ip_addr_t                dest_reg, dest_next;
    logic [15:0]             dport_reg, dport_next;
    if_port_t                held_port_reg, held_port_next;
    logic                    held_ip6_reg, held_ip6_next;

    // result register and counters
    logic                     out_valid_reg, out_valid_next;
    logic                     verdict_reg, verdict_next;
    logic [COUNTER_WIDTH-1:0] lan_cnt_reg, lan_cnt_next;
    logic [COUNTER_WIDTH-1:0] ap_cnt_reg, ap_cnt_next;
    logic [COUNTER_WIDTH-1:0] drop_cnt_reg, drop_cnt_next;

    logic out_free, advance, close_pkt;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = item_valid_reg && (!item_last_reg || out_free);
    assign in_ready  = !item_valid_reg || advance;
    assign close_pkt = advance && item_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lan_addr_reg <= '0;
            ap_addr_reg  <= '0;
            ap_mask_reg  <= '0;
            up_addr_reg  <= '0;
            up_mask_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LAN_ADDRESS:    lan_addr_reg <= cfg_data;
                CFG_AP_ADDRESS:     ap_addr_reg  <= cfg_data;
                CFG_AP_MASK:        ap_mask_reg  <= cfg_data;
                CFG_UPLINK_ADDRESS: up_addr_reg  <= cfg_data;
                CFG_UPLINK_MASK:    up_mask_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_port_reg  <= port_in;
            item_ip6_reg   <= ip6_path;
            item_byte_reg  <= data_byte;
            item_first_reg <= first_byte;
            item_last_reg  <= last_byte;
        end
    end

    // byte capture
    logic [LENGTH_WIDTH-1:0] pos;
    logic [15:0]             pos16;
    logic [15:0]             hdr_len;
    logic                    pkt_start;

    always_comb
    begin
        pkt_start      = item_first_reg || (byte_index_reg == '0);
        held_port_next = pkt_start ? item_port_reg : held_port_reg;
        held_ip6_next  = pkt_start ? item_ip6_reg : held_ip6_reg;
        vihl_next      = pkt_start ? '0 : vihl_reg;
        len_next       = pkt_start ? '0 : len_reg;
        proto_next     = pkt_start ? '0 : proto_reg;
        frag_next      = pkt_start ? '0 : frag_reg;
        dest_next      = pkt_start ? '0 : dest_reg;
        dport_next     = pkt_start ? '0 : dport_reg;
        pos            = pkt_start ? '0 : byte_index_reg;
        pos16          = 16'(pos);
        hdr_len        = {10'd0, vihl_next[3:0], 2'b00};
        byte_index_next = pos;

        if (pos != LEN_MAX)
        begin
            byte_index_next = pos + 1'b1;
            if (pos16 == OFS_VIHL)
                vihl_next = item_byte_reg;
            else if (pos16 == OFS_LEN_HI)
                len_next[15:8] = item_byte_reg;
            else if (pos16 == OFS_LEN_LO)
                len_next[7:0] = item_byte_reg;
            else if (pos16 == OFS_FRAG_HI)
                frag_next[12:8] = item_byte_reg[4:0] & FRAG_HI_MASK;
            else if (pos16 == OFS_FRAG_LO)
                frag_next[7:0] = item_byte_reg;
            else if (pos16 == OFS_PROTO)
                proto_next = item_byte_reg;
            else if (pos16 >= OFS_DEST_LO && pos16 <= OFS_DEST_HI)
                dest_next = {dest_next[23:0], item_byte_reg};

            if (hdr_len >= MIN_HDR_BYTES && pos16 >= MIN_HDR_BYTES)
            begin
                if (pos16 == hdr_len + OFS_DPORT_HI)
                    dport_next[15:8] = item_byte_reg;
                else if (pos16 == hdr_len + OFS_DPORT_LO)
                    dport_next[7:0] = item_byte_reg;
            end
        end
    end

    // verdict on the captured header
    logic       on_lan, on_ap, hdr_bad, bcast, is_local, is_l4, too_short;
    logic       ap_exempt, mgmt, drop;
    logic [15:0] cnt16, ihl16;
    ip_addr_t   if_addr, if_mask;

    always_comb
    begin
        on_lan  = (held_port_next == PORT_LAN);
        on_ap   = (held_port_next == PORT_AP);
        cnt16   = 16'(byte_index_next);
        ihl16   = {10'd0, vihl_next[3:0], 2'b00};
        hdr_bad = (cnt16 < MIN_HDR_BYTES) || (vihl_next[7:4] != IP_VERSION4)
                  || (ihl16 < MIN_HDR_BYTES) || (len_next < ihl16) || (len_next > cnt16);

        if_addr = on_ap ? ap_addr_reg : up_addr_reg;
        if_mask = on_ap ? ap_mask_reg : up_mask_reg;
        bcast   = (dest_next == ADDR_ONES) || (dest_next == ADDR_ZERO)
                  || ((dest_next != if_addr)
                      && ((dest_next & if_mask) == (if_addr & if_mask))
                      && ((dest_next | if_mask) == ADDR_ONES));
        is_local = (dest_next == MDNS_GROUP) || bcast || (dest_next == lan_addr_reg)
                   || (dest_next == ap_addr_reg) || (dest_next == up_addr_reg);

        is_l4     = (proto_next == PROTO_TCP) || (proto_next == PROTO_UDP);
        too_short = len_next < (ihl16 + PORTS_BYTES);
        ap_exempt = on_ap && (dest_next == ap_addr_reg)
                    && ((dport_next == SVC_DNS) || (dport_next == SVC_HTTP)
                        || (dport_next == SVC_HTTPS));
        mgmt = ((proto_next == PROTO_TCP)
                && ((dport_next == SVC_HTTP) || (dport_next == SVC_HTTPS)
                    || (dport_next == SVC_DNS)))
            || ((proto_next == PROTO_UDP)
                && ((dport_next == SVC_DNS) || (dport_next == SVC_MDNS)
                    || (dport_next == SVC_MGMT_A) || (dport_next == SVC_MGMT_B)));

        if (held_ip6_next)
            drop = 1'b1;
        else if (on_lan)
            drop = 1'b0;
        else if (hdr_bad)
            drop = 1'b1;
        else if (!is_local || !is_l4 || (frag_next != '0))
            drop = 1'b0;
        else if (too_short)
            drop = 1'b1;
        else if (ap_exempt)
            drop = 1'b0;
        else
            drop = mgmt;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        verdict_next   = verdict_reg;
        lan_cnt_next   = lan_cnt_reg;
        ap_cnt_next    = ap_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        if (close_pkt)
        begin
            out_valid_next = 1'b1;
            verdict_next   = drop;
            if (!held_ip6_next && on_lan)
                lan_cnt_next = lan_cnt_reg + 1'b1;
            if (!held_ip6_next && on_ap)
                ap_cnt_next = ap_cnt_reg + 1'b1;
            if (drop)
                drop_cnt_next = drop_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            lan_cnt_reg    <= '0;
            ap_cnt_reg     <= '0;
            drop_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            lan_cnt_reg   <= lan_cnt_next;
            ap_cnt_reg    <= ap_cnt_next;
            drop_cnt_reg  <= drop_cnt_next;
            if (advance)
                byte_index_reg <= item_last_reg ? '0 : byte_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (advance)
        begin
            vihl_reg      <= vihl_next;
            len_reg       <= len_next;
            proto_reg     <= proto_next;
            frag_reg      <= frag_next;
            dest_reg      <= dest_next;
            dport_reg     <= dport_next;
            held_port_reg <= held_port_next;
            held_ip6_reg  <= held_ip6_next;
        end
    end

    logic [63:0] lan_ext, ap_ext, drop_ext;

    assign lan_ext  = 64'(lan_cnt_reg);
    assign ap_ext   = 64'(ap_cnt_reg);
    assign drop_ext = 64'(drop_cnt_reg);

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign lan_rx_total = lan_ext[31:0];
    assign ap_rx_total  = ap_ext[31:0];
    assign denied_total = drop_ext[31:0];

endmodule
